[sv/gbff_pkg.sv]
// Shared types, constants and id tables for the binary frame filter.
`timescale 1ns / 1ps
`default_nettype none
package gbff_pkg;

  localparam logic [7:0] SYNC_A     = 8'hB5;
  localparam logic [7:0] SYNC_B     = 8'h62;
  localparam logic [7:0] CLASS_NAV  = 8'h01;
  localparam logic [7:0] CLASS_MON  = 8'h0A;
  localparam logic [6:0] HEADER_LEN = 7'd5;

  localparam logic [7:0] ID_A = 8'h07;
  localparam logic [7:0] ID_B = 8'h04;
  localparam logic [7:0] ID_C = 8'h20;
  localparam logic [7:0] ID_D = 8'h0B;
  localparam logic [7:0] ID_E = 8'h09;

  localparam logic [2:0] BEAT_LAST = 3'd4;

  // Job handed from the parser to the output sequencer.
  typedef struct packed {
    logic       is_header;
    logic [7:0] class_code;
    logic [7:0] message_id;
    logic [7:0] data;
    logic       last;
    logic [6:0] frame_length;
  } job_t;

  // Body bytes for an id, zero when the id is not accepted.
  function automatic logic [6:0] body_for_id(input logic [7:0] id);
    case (id)
      ID_A:    body_for_id = 7'd95;
      ID_B:    body_for_id = 7'd21;
      ID_C:    body_for_id = 7'd19;
      ID_D:    body_for_id = 7'd31;
      ID_E:    body_for_id = 7'd63;
      default: body_for_id = 7'd0;
    endcase
  endfunction

  // True when id is accepted and len is its expected length byte.
  function automatic logic length_ok(input logic [7:0] id, input logic [7:0] len);
    case (id)
      ID_A:    length_ok = (len == 8'h5C);
      ID_B:    length_ok = (len == 8'h12);
      ID_C:    length_ok = (len == 8'h10);
      ID_D:    length_ok = (len == 8'h1C);
      ID_E:    length_ok = (len == 8'h3C);
      default: length_ok = 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

[sv/gbff_front.sv]
// Frame parser: takes one byte per transfer and issues header or body jobs.
`timescale 1ns / 1ps
`default_nettype none
module gbff_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    rx_byte,
  output gbff_pkg::job_t     job,
  output logic               job_push
);

  typedef enum logic [5:0] {
    PH_SYNC_A = 6'b000001,
    PH_SYNC_B = 6'b000010,
    PH_CLASS  = 6'b000100,
    PH_ID     = 6'b001000,
    PH_LEN    = 6'b010000,
    PH_BODY   = 6'b100000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] class_code, class_code_next;
  logic [7:0] message_id, message_id_next;
  logic [6:0] body_target, body_target_next;
  logic [6:0] body_count, body_count_next;
  logic       emit;
  logic       fwd;
  logic [6:0] count_inc;
  logic [6:0] id_body;

  assign id_body = gbff_pkg::body_for_id(rx_byte);
  assign fwd = body_count < body_target;
  assign count_inc = fwd ? body_count + 7'd1 : body_count;

  always_comb begin
    phase_next       = phase;
    class_code_next  = class_code;
    message_id_next  = message_id;
    body_target_next = body_target;
    body_count_next  = body_count;
    emit             = 1'b0;
    job              = '0;
    case (phase)
      PH_SYNC_B: begin
        phase_next = (rx_byte == gbff_pkg::SYNC_B) ? PH_CLASS : PH_SYNC_A;
      end
      PH_CLASS: begin
        if (rx_byte == gbff_pkg::CLASS_NAV || rx_byte == gbff_pkg::CLASS_MON) begin
          class_code_next = rx_byte;
          phase_next      = PH_ID;
        end else begin
          phase_next = PH_SYNC_A;
        end
      end
      PH_ID: begin
        if (id_body != 7'd0) begin
          message_id_next  = rx_byte;
          body_target_next = id_body;
          phase_next       = PH_LEN;
        end else begin
          phase_next = PH_SYNC_A;
        end
      end
      PH_LEN: begin
        if (gbff_pkg::length_ok(message_id, rx_byte)) begin
          body_count_next = 7'd0;
          emit            = 1'b1;
          job.is_header   = 1'b1;
          job.class_code  = class_code;
          job.message_id  = message_id;
          job.data        = rx_byte;
          phase_next      = PH_BODY;
        end else begin
          phase_next = PH_ID;
        end
      end
      PH_BODY: begin
        job.data = rx_byte;
        if (count_inc >= body_target) begin
          emit             = fwd;
          job.last         = 1'b1;
          job.frame_length = body_target + gbff_pkg::HEADER_LEN;
          body_count_next  = 7'd0;
          body_target_next = 7'd0;
          phase_next       = PH_SYNC_A;
        end else begin
          emit            = 1'b1;
          body_count_next = count_inc;
        end
      end
      default: begin
        phase_next = (rx_byte == gbff_pkg::SYNC_A) ? PH_SYNC_B : PH_SYNC_A;
      end
    endcase
  end

  assign job_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC_A;
      class_code  <= 8'd0;
      message_id  <= 8'd0;
      body_target <= 7'd0;
      body_count  <= 7'd0;
    end else if (accept) begin
      phase       <= phase_next;
      class_code  <= class_code_next;
      message_id  <= message_id_next;
      body_target <= body_target_next;
      body_count  <= body_count_next;
    end
  end

endmodule
`default_nettype wire

[sv/gbff_queue.sv]
// Short job queue between the parser and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none
module gbff_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire gbff_pkg::job_t wr_data,
  output logic                full,
  input  wire logic           pop,
  output gbff_pkg::job_t      rd_data,
  output logic                valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  gbff_pkg::job_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CNT_FULL);
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[sv/gbff_back.sv]
// Output sequencer: expands header jobs into five bytes and holds the current result.
`timescale 1ns / 1ps
`default_nettype none
module gbff_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire gbff_pkg::job_t q_data,
  input  wire logic          q_valid,
  output logic               q_pop,
  output logic               empty,
  input  wire logic          pop,
  output logic [7:0]         out_byte,
  output logic               frame_last,
  output logic [6:0]         frame_length
);

  gbff_pkg::job_t cur;
  logic           cur_valid;
  logic [2:0]     beat;
  logic           beat_last;
  logic           advance;
  logic           load;

  assign beat_last = !cur.is_header || (beat == gbff_pkg::BEAT_LAST);
  assign advance   = cur_valid && pop;
  assign load      = !cur_valid || (advance && beat_last);
  assign q_pop     = load && q_valid;
  assign empty     = !cur_valid;

  always_comb begin
    out_byte     = cur.data;
    frame_last   = cur.last;
    frame_length = cur.frame_length;
    if (cur.is_header) begin
      frame_last   = 1'b0;
      frame_length = 7'd0;
      case (beat)
        3'd0:    out_byte = gbff_pkg::SYNC_A;
        3'd1:    out_byte = gbff_pkg::SYNC_B;
        3'd2:    out_byte = cur.class_code;
        3'd3:    out_byte = cur.message_id;
        default: out_byte = cur.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      beat      <= 3'd0;
    end else if (load) begin
      cur_valid <= q_valid;
      beat      <= 3'd0;
    end else if (advance) begin
      beat <= beat + 3'd1;
    end
  end

endmodule
`default_nettype wire

[sv/gnss_binary_frame_filter_core.sv]
// Top level of the binary navigation frame filter.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one received byte per cycle while full is low. A parser finds the
// sync pair, class, id and matching length byte, then forwards the body bytes
// (length high byte, payload, checksum); the last byte carries frame_last and
// the total frame length. Each accepted byte yields at most one job in a
// QUEUE_DEPTH-entry queue; while pop is high the output sequencer drains one
// result per cycle, expanding a header job into its five bytes. A job is
// written into the queue and then loaded into the sequencer's current-result
// register before its result can be popped. With pop held high the six-entry
// queue absorbs the extra header bytes, so input takes a byte every cycle;
// input stalls only when the job queue fills, which happens when pop is held
// low or slow.
module gnss_binary_frame_filter_core #(
  parameter int QUEUE_DEPTH = 6
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            frame_last,
  output logic [6:0]      frame_length
);

  gbff_pkg::job_t job;
  gbff_pkg::job_t q_data;
  logic           job_push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic           accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  gbff_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .job      (job),
    .job_push (job_push)
  );

  gbff_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .wr_data (job),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_data),
    .valid   (q_valid)
  );

  gbff_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_data),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .frame_last   (frame_last),
    .frame_length (frame_length)
  );

endmodule
`default_nettype wire

[verif/gnss_binary_frame_filter_core_tb.sv]
// Self-checking testbench for the binary frame filter core: directed table, then random frames.
`timescale 1ns / 1ps
module gnss_binary_frame_filter_core_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 470;
  localparam int DIR_N       = 25;

  typedef enum logic [2:0] {
    HUNT_A, HUNT_B, GET_CLASS, GET_ID, GET_LEN, FORWARD
  } parse_st_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [6:0] flen;
  } frame_beat_t;

  // One directed row: byte to send, whether the results are typed in, how many, header bytes.
  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    logic [2:0]  n_res;
    logic [39:0] hdr;
  } dir_row_t;

  localparam dir_row_t [0:DIR_N-1] DIR_TAB = {
    {8'h00, 1'b1, 3'd0, 40'h0},                  // idle hunt, low extreme
    {8'hFF, 1'b1, 3'd0, 40'h0},                  // idle hunt, high extreme
    {8'hB5, 1'b1, 3'd0, 40'h0},
    {8'hB5, 1'b1, 3'd0, 40'h0},                  // repeated first sync breaks the pair
    {8'h62, 1'b1, 3'd0, 40'h0},                  // second sync alone is ignored
    {8'hB5, 1'b1, 3'd0, 40'h0},
    {8'h62, 1'b1, 3'd0, 40'h0},
    {8'h02, 1'b1, 3'd0, 40'h0},                  // bad class
    {8'hB5, 1'b1, 3'd0, 40'h0},
    {8'h62, 1'b1, 3'd0, 40'h0},
    {8'h0A, 1'b1, 3'd0, 40'h0},
    {8'h0A, 1'b1, 3'd0, 40'h0},                  // bad id
    {8'hB5, 1'b1, 3'd0, 40'h0},
    {8'h62, 1'b1, 3'd0, 40'h0},
    {8'h01, 1'b1, 3'd0, 40'h0},
    {8'h20, 1'b1, 3'd0, 40'h0},
    {8'h11, 1'b1, 3'd0, 40'h0},                  // bad length, back to id wait
    {8'h04, 1'b1, 3'd0, 40'h0},                  // new id replaces the stored one
    {8'h12, 1'b1, 3'd5, 40'hB5_62_01_04_12},     // header burst
    {8'h00, 1'b0, 3'd0, 40'h0},
    {8'hFF, 1'b0, 3'd0, 40'h0},
    {8'h55, 1'b0, 3'd0, 40'h0},
    {8'hAA, 1'b0, 3'd0, 40'h0},
    {8'hB5, 1'b0, 3'd0, 40'h0},                  // sync bytes inside a body are data
    {8'h62, 1'b0, 3'd0, 40'h0}
  };

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] rx_byte;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       frame_last;
  logic [6:0] frame_length;

  gnss_binary_frame_filter_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .frame_last   (frame_last),
    .frame_length (frame_length)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predicted parser state.
  parse_st_t  st = HUNT_A;
  logic [7:0] cur_class = 8'h00;
  logic [7:0] cur_id = 8'h00;
  logic [6:0] tgt = 7'd0;
  logic [6:0] cnt = 7'd0;

  frame_beat_t beat_q[$];
  int          bad_cnt = 0;
  int          cycles = 0;
  int          sent_n = 0;
  bit          calm = 1'b0;

  // Expected length byte and body size per id.
  function automatic void id_layout(input logic [7:0] id, output logic ok,
                                    output logic [7:0] lenb, output logic [6:0] body);
    ok = 1'b1;
    case (id)
      gbff_pkg::ID_A: begin lenb = 8'h5C; body = 7'd95; end
      gbff_pkg::ID_B: begin lenb = 8'h12; body = 7'd21; end
      gbff_pkg::ID_C: begin lenb = 8'h10; body = 7'd19; end
      gbff_pkg::ID_D: begin lenb = 8'h1C; body = 7'd31; end
      gbff_pkg::ID_E: begin lenb = 8'h3C; body = 7'd63; end
      default:        begin ok = 1'b0; lenb = 8'h00; body = 7'd0; end
    endcase
  endfunction

  // Advance the predicted parser by one byte; queue its output beats when keep is set.
  task automatic track_byte(input logic [7:0] b, input bit keep);
    logic       ok;
    logic [7:0] lenb;
    logic [6:0] body;
    bit         fwd;
    case (st)
      HUNT_B: st = (b == gbff_pkg::SYNC_B) ? GET_CLASS : HUNT_A;
      GET_CLASS: begin
        if (b == gbff_pkg::CLASS_NAV || b == gbff_pkg::CLASS_MON) begin
          cur_class = b;
          st = GET_ID;
        end else begin
          st = HUNT_A;
        end
      end
      GET_ID: begin
        id_layout(b, ok, lenb, body);
        if (ok) begin
          cur_id = b;
          tgt = body;
          st = GET_LEN;
        end else begin
          st = HUNT_A;
        end
      end
      GET_LEN: begin
        id_layout(cur_id, ok, lenb, body);
        if (ok && b == lenb) begin
          cnt = 7'd0;
          if (keep) begin
            beat_q.push_back('{gbff_pkg::SYNC_A, 1'b0, 7'd0});
            beat_q.push_back('{gbff_pkg::SYNC_B, 1'b0, 7'd0});
            beat_q.push_back('{cur_class, 1'b0, 7'd0});
            beat_q.push_back('{cur_id, 1'b0, 7'd0});
            beat_q.push_back('{b, 1'b0, 7'd0});
          end
          st = FORWARD;
        end else begin
          st = GET_ID;
        end
      end
      FORWARD: begin
        fwd = cnt < tgt;
        if (fwd) cnt = cnt + 7'd1;
        if (cnt >= tgt) begin
          if (fwd && keep) beat_q.push_back('{b, 1'b1, tgt + gbff_pkg::HEADER_LEN});
          cnt = 7'd0;
          tgt = 7'd0;
          st = HUNT_A;
        end else if (keep) begin
          beat_q.push_back('{b, 1'b0, 7'd0});
        end
      end
      default: st = (b == gbff_pkg::SYNC_A) ? HUNT_B : HUNT_A;
    endcase
  endtask

  // Entered at a falling edge; returns at the falling edge after the transfer.
  task automatic put_byte(input dir_row_t r);
    int k;
    while (!calm && $urandom_range(0, 99) < 28) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    rx_byte <= r.rx;
    @(posedge clk);
    while (full) @(posedge clk);
    if (r.typed) begin
      track_byte(r.rx, 1'b0);
      for (k = 0; k < r.n_res; k++) beat_q.push_back('{r.hdr[39 - 8 * k -: 8], 1'b0, 7'd0});
    end else begin
      track_byte(r.rx, 1'b1);
    end
    calm = (sent_n >= 180 && sent_n < 300);
    @(negedge clk);
  endtask

  task automatic put_rand(input logic [7:0] b, input bit counted);
    put_byte({b, 1'b0, 3'd0, 40'h0});
    if (counted) sent_n++;
  endtask

  // Hold the sender off until every predicted beat has been popped.
  task automatic hold_until_drained();
    push <= 1'b0;
    @(negedge clk);
    while (beat_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_id();
    case ($urandom_range(0, 4))
      0:       return gbff_pkg::ID_A;
      1:       return gbff_pkg::ID_B;
      2:       return gbff_pkg::ID_C;
      3:       return gbff_pkg::ID_D;
      default: return gbff_pkg::ID_E;
    endcase
  endfunction

  // Whole frame with random class, id and body; retry sends a wrong length and a new id first.
  task automatic send_frame(input bit retry);
    logic [7:0] cls;
    logic [7:0] id;
    logic [7:0] lenb;
    logic [7:0] junk;
    logic [6:0] body;
    logic       ok;
    int         i;
    cls = $urandom_range(0, 1) ? gbff_pkg::CLASS_MON : gbff_pkg::CLASS_NAV;
    id = pick_id();
    put_rand(gbff_pkg::SYNC_A, 1'b1);
    put_rand(gbff_pkg::SYNC_B, 1'b1);
    put_rand(cls, 1'b1);
    put_rand(id, 1'b1);
    id_layout(id, ok, lenb, body);
    if (retry) begin
      do junk = 8'($urandom_range(0, 255)); while (junk == lenb);
      put_rand(junk, 1'b1);
      id = pick_id();
      put_rand(id, 1'b1);
      id_layout(id, ok, lenb, body);
    end
    put_rand(lenb, 1'b1);
    for (i = 0; i < body; i++) put_rand(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Header cut short at a random point.
  task automatic send_broken();
    logic [7:0] b;
    logic [7:0] lenb;
    logic [6:0] body;
    logic       ok;
    int         kind;
    kind = $urandom_range(0, 3);
    put_rand(gbff_pkg::SYNC_A, 1'b1);
    if (kind == 0) begin
      do b = 8'($urandom_range(0, 255)); while (b == gbff_pkg::SYNC_B);
      if ($urandom_range(0, 3) == 0) b = gbff_pkg::SYNC_A;
      put_rand(b, 1'b1);
    end else begin
      put_rand(gbff_pkg::SYNC_B, 1'b1);
      if (kind == 1) begin
        do b = 8'($urandom_range(0, 255));
        while (b == gbff_pkg::CLASS_NAV || b == gbff_pkg::CLASS_MON);
        put_rand(b, 1'b1);
      end else begin
        put_rand($urandom_range(0, 1) ? gbff_pkg::CLASS_MON : gbff_pkg::CLASS_NAV, 1'b1);
        if (kind == 2) begin
          do begin
            b = 8'($urandom_range(0, 255));
            id_layout(b, ok, lenb, body);
          end while (ok);
          put_rand(b, 1'b1);
        end else begin
          b = pick_id();
          put_rand(b, 1'b1);
          id_layout(b, ok, lenb, body);
          do b = 8'($urandom_range(0, 255)); while (b == lenb);
          put_rand(b, 1'b1);
        end
      end
    end
  endtask

  task automatic note_bad(input string what, input frame_beat_t want, input frame_beat_t got);
    bad_cnt++;
    if (bad_cnt <= 10)
      $display("%0t: %s: exp byte=%02h last=%0d len=%0d, got byte=%02h last=%0d len=%0d",
               $realtime, what, want.data, want.last, want.flen, got.data, got.last, got.flen);
  endtask

  always @(negedge clk) pop <= !rst && (calm || $urandom_range(0, 99) >= 28);

  // Result monitor and run limit.
  always @(posedge clk) begin : mon
    frame_beat_t want;
    frame_beat_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gnss_binary_frame_filter_core verification failed");
      $finish;
    end
    if (!rst && pop && !empty) begin
      got = '{out_byte, frame_last, frame_length};
      if (beat_q.size() == 0) begin
        note_bad("unexpected transfer", '0, got);
      end else begin
        want = beat_q.pop_front();
        if (got.data !== want.data || got.last !== want.last || got.flen !== want.flen)
          note_bad("mismatch", want, got);
      end
    end
  end

  initial begin : stim
    int i;
    int pick;
    rst = 1'b1;
    push = 1'b0;
    rx_byte = 8'h00;
    pop = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < DIR_N; i++) put_byte(DIR_TAB[i]);
    // finish the directed frame with random body bytes
    while (st == FORWARD) put_rand(8'($urandom_range(0, 255)), 1'b1);
    hold_until_drained();

    while (sent_n < RAND_ITEMS) begin
      if ($urandom_range(0, 9) == 0) hold_until_drained();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame(1'b0);
      end else if (pick < 72) begin
        send_frame(1'b1);
      end else if (pick < 92) begin
        send_broken();
      end else begin
        repeat ($urandom_range(1, 6)) put_rand(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    push <= 1'b0;

    while (beat_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (bad_cnt == 0) begin
      $display("gnss_binary_frame_filter_core verification clean");
    end else begin
      $display("gnss_binary_frame_filter_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/gbff_pkg.sv
sv/gbff_front.sv
sv/gbff_queue.sv
sv/gbff_back.sv
sv/gnss_binary_frame_filter_core.sv
verif/gnss_binary_frame_filter_core_tb.sv
